@@ rtl/isl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package isl_pkg;

  // List capacity and the fixed widths of the index and count fields
  localparam int unsigned DEPTH = 16;
  localparam int unsigned CNT_W = 5;
  localparam int unsigned POS_W = 5;
  localparam int unsigned ACT_W = 3;
  localparam int unsigned ST_W  = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_ERASE  = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_READ   = 3'd4
  } action_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Edit broadcast to every cell in the row
  typedef enum logic [1:0] {
    EDIT_NONE   = 2'd0,
    EDIT_APPEND = 2'd1,
    EDIT_INSERT = 2'd2,
    EDIT_ERASE  = 2'd3
  } edit_e;

  typedef struct packed {
    edit_e             kind;
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  count;
  } edit_t;

  // Lookup broadcast to every cell: which entries drive the read and back words
  typedef struct packed {
    logic              rd_en;
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  count;
  } probe_t;

endpackage

`default_nettype wire

@@ rtl/isl_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module isl_cell
  import isl_pkg::*;
#(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned INDEX = 0
) (
  input  wire              clk_i,
  input  edit_t            edit_i,
  input  wire  [WIDTH-1:0] value_i,
  input  wire  [WIDTH-1:0] left_i,
  input  wire  [WIDTH-1:0] right_i,
  input  probe_t           probe_i,
  output logic [WIDTH-1:0] data_o,
  output logic [WIDTH-1:0] rd_word_o,
  output logic [WIDTH-1:0] back_word_o
);

  localparam logic [CNT_W-1:0] Idx     = CNT_W'(INDEX);
  localparam logic [CNT_W:0]   IdxNext = (CNT_W+1)'(INDEX + 1);

  logic [WIDTH-1:0] data_q, data_d;

  // Pick this entry's next word: hold, load, take from the left or the right
  always_comb begin
    data_d = data_q;
    unique case (edit_i.kind)
      EDIT_APPEND: begin
        if (Idx == edit_i.count) data_d = value_i;
      end
      EDIT_INSERT: begin
        if (Idx == edit_i.pos) begin
          data_d = value_i;
        end else if (Idx > edit_i.pos && Idx <= edit_i.count) begin
          data_d = left_i;
        end
      end
      EDIT_ERASE: begin
        if (Idx >= edit_i.pos && IdxNext < {1'b0, edit_i.count}) data_d = right_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

  // Offer the word where this entry is the read target or the last entry
  assign rd_word_o   = (probe_i.rd_en && Idx == probe_i.pos) ? data_q : '0;
  assign back_word_o = (IdxNext == {1'b0, probe_i.count}) ? data_q : '0;

endmodule

`default_nettype wire

@@ rtl/indexed_shift_list_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Word fields (low bit first)
// s_axis    in   action[2:0], position[7:3], elem_value[WIDTH+7:8]
// m_axis    out  read_value, front_value, back_value, element_count, status
//
// One item per cycle sustained while the output is not stalled. An accepted
// item edits the row of cells at its acceptance edge (all entries shift at
// once) and waits in the pending stage; its result is taken from the cells
// into the output register once that register is empty or being read. A
// stalled result holds the next item in the pending stage and stops input;
// reset empties the list and drops both stages.
module indexed_shift_list_unit
  import isl_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // action, position, elem_value
  input  wire  [((ACT_W+POS_W+WIDTH+7)/8)*8-1:0]   s_axis_tdata_i,
  output logic                                    m_axis_tvalid_o,
  input  wire                                     m_axis_tready_i,
  // read_value, front_value, back_value, element_count, status
  output logic [((3*WIDTH+CNT_W+ST_W+7)/8)*8-1:0]  m_axis_tdata_o
);

  localparam int unsigned PosLo = ACT_W;
  localparam int unsigned ValLo = ACT_W + POS_W;
  localparam int unsigned CntLo = 3 * WIDTH;
  localparam int unsigned StLo  = 3 * WIDTH + CNT_W;

  action_e          act;
  logic [POS_W-1:0] pos;
  logic [WIDTH-1:0] val;
  logic             in_fire, cap;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pend_q;
  logic             rd_q;
  status_e          st_q, st_d;
  logic [POS_W-1:0] pos_q;
  logic             out_valid_q;
  logic [WIDTH-1:0] rd_out_q, front_out_q, back_out_q;
  logic [CNT_W-1:0] cnt_out_q;
  status_e          st_out_q;

  edit_t            edit;
  probe_t           probe;
  logic [WIDTH-1:0] cell_data [DEPTH];
  logic [WIDTH-1:0] cell_rd   [DEPTH];
  logic [WIDTH-1:0] cell_back [DEPTH];
  logic [WIDTH-1:0] rd_word, back_word, front_word;

  // Unpack the input word
  assign act = action_e'(s_axis_tdata_i[ACT_W-1:0]);
  assign pos = s_axis_tdata_i[PosLo +: POS_W];
  assign val = s_axis_tdata_i[ValLo +: WIDTH];

  assign cap             = pend_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !pend_q || cap;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // Check the action against the count and form the edit for the row
  always_comb begin
    st_d       = ST_OK;
    cnt_d      = cnt_q;
    edit.kind  = EDIT_NONE;
    edit.pos   = pos;
    edit.count = cnt_q;
    unique case (act)
      ACT_APPEND: begin
        if (cnt_q >= CNT_W'(DEPTH)) begin
          st_d = ST_FULL;
        end else begin
          edit.kind = EDIT_APPEND;
          cnt_d     = cnt_q + 1'b1;
        end
      end
      ACT_INSERT: begin
        if (cnt_q >= CNT_W'(DEPTH)) begin
          st_d = ST_FULL;
        end else if (pos > cnt_q) begin
          st_d = ST_RANGE;
        end else begin
          edit.kind = EDIT_INSERT;
          cnt_d     = cnt_q + 1'b1;
        end
      end
      ACT_ERASE: begin
        if (cnt_q == '0) begin
          st_d = ST_EMPTY;
        end else if (pos >= cnt_q) begin
          st_d = ST_RANGE;
        end else begin
          edit.kind = EDIT_ERASE;
          cnt_d     = cnt_q - 1'b1;
        end
      end
      ACT_CLEAR: begin
        cnt_d = '0;
      end
      ACT_READ: begin
        if (cnt_q == '0) begin
          st_d = ST_EMPTY;
        end else if (pos >= cnt_q) begin
          st_d = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
    if (!in_fire) begin
      edit.kind = EDIT_NONE;
      cnt_d     = cnt_q;
    end
  end

  // Hold count and the pending item's lookup info
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (in_fire) begin
        pend_q <= 1'b1;
      end else if (cap) begin
        pend_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_q  <= (act == ACT_READ) && (st_d == ST_OK);
      st_q  <= st_d;
      pos_q <= pos;
    end
  end

  assign probe.rd_en = rd_q;
  assign probe.pos   = pos_q;
  assign probe.count = cnt_q;

  // Row of cells, each linked to its left and right neighbors (zero at the ends)
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    isl_cell #(
      .WIDTH (WIDTH),
      .INDEX (i)
    ) u_cell (
      .clk_i       (clk_i),
      .edit_i      (edit),
      .value_i     (val),
      .left_i      (left),
      .right_i     (right),
      .probe_i     (probe),
      .data_o      (cell_data[i]),
      .rd_word_o   (cell_rd[i]),
      .back_word_o (cell_back[i])
    );
  end

  // Merge the words offered by the cells
  always_comb begin
    rd_word   = '0;
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word   = rd_word | cell_rd[i];
      back_word = back_word | cell_back[i];
    end
  end

  assign front_word = (cnt_q != '0) ? cell_data[0] : '0;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cap) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap) begin
      rd_out_q    <= rd_word;
      front_out_q <= front_word;
      back_out_q  <= back_word;
      cnt_out_q   <= cnt_q;
      st_out_q    <= st_q;
    end
  end

  // Pack the output word
  always_comb begin
    m_axis_tdata_o                  = '0;
    m_axis_tdata_o[0 +: WIDTH]      = rd_out_q;
    m_axis_tdata_o[WIDTH +: WIDTH]  = front_out_q;
    m_axis_tdata_o[2*WIDTH +: WIDTH] = back_out_q;
    m_axis_tdata_o[CntLo +: CNT_W]  = cnt_out_q;
    m_axis_tdata_o[StLo +: ST_W]    = st_out_q;
  end

  assign m_axis_tvalid_o = out_valid_q;

endmodule

`default_nettype wire

@@ tb/tb_indexed_shift_list_unit.sv @@
`timescale 1ns / 1ps

module tb_indexed_shift_list_unit;
  import isl_pkg::*;

  localparam int unsigned WIDTH = 32;
  localparam int unsigned S_W = ((ACT_W + POS_W + WIDTH + 7) / 8) * 8;
  localparam int unsigned M_W = ((3 * WIDTH + CNT_W + ST_W + 7) / 8) * 8;
  localparam int unsigned RANDOM_OPS = 1150;
  localparam int unsigned IDLE_PCT = 27;

  // One list operation as it goes onto the input stream
  typedef struct {
    logic [ACT_W-1:0] act;
    logic [POS_W-1:0] pos;
    logic [WIDTH-1:0] val;
    bit               drain_first;
  } list_op_t;

  // What the list reports after one operation
  typedef struct {
    logic [WIDTH-1:0] rd;
    logic [WIDTH-1:0] front;
    logic [WIDTH-1:0] back;
    logic [CNT_W-1:0] len;
    status_e          st;
  } list_view_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           s_valid = 1'b0;
  logic [S_W-1:0] s_data = '0;
  logic           m_ready = 1'b0;
  logic           s_axis_tready_o;
  logic           m_axis_tvalid_o;
  logic [M_W-1:0] m_axis_tdata_o;

  list_op_t   op_queue[$];
  list_view_t view_queue[$];
  list_op_t   cur_op;

  // Shadow copy of the list, advanced at each accepted word
  logic [WIDTH-1:0] shadow_cells[DEPTH];
  int unsigned      shadow_len = 0;

  // Length tracked while building stimulus, to aim positions at live entries
  int unsigned gen_len = 0;

  int  n_sent = 0;
  int  n_recv = 0;
  int  fail_cnt = 0;
  wire calm = (n_sent >= 300) && (n_sent < 550);

  indexed_shift_list_unit #(
    .WIDTH(WIDTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    // action, position, elem_value
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    // read_value, front_value, back_value, element_count, status
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Apply one operation to the shadow list and queue the view it should report
  function automatic void apply_list_op(input list_op_t op);
    list_view_t v;
    int i;
    v.rd = '0;
    v.st = ST_OK;
    case (op.act)
      ACT_APPEND: begin
        if (shadow_len >= DEPTH) begin
          v.st = ST_FULL;
        end else begin
          shadow_cells[shadow_len] = op.val;
          shadow_len++;
        end
      end
      ACT_INSERT: begin
        if (shadow_len >= DEPTH) begin
          v.st = ST_FULL;
        end else if (op.pos > shadow_len) begin
          v.st = ST_RANGE;
        end else begin
          for (i = shadow_len; i > op.pos; i--) shadow_cells[i] = shadow_cells[i-1];
          shadow_cells[op.pos] = op.val;
          shadow_len++;
        end
      end
      ACT_ERASE: begin
        if (shadow_len == 0) begin
          v.st = ST_EMPTY;
        end else if (op.pos >= shadow_len) begin
          v.st = ST_RANGE;
        end else begin
          for (i = op.pos; i + 1 < shadow_len; i++) shadow_cells[i] = shadow_cells[i+1];
          shadow_len--;
        end
      end
      ACT_CLEAR: begin
        shadow_len = 0;
      end
      ACT_READ: begin
        if (shadow_len == 0) begin
          v.st = ST_EMPTY;
        end else if (op.pos >= shadow_len) begin
          v.st = ST_RANGE;
        end else begin
          v.rd = shadow_cells[op.pos];
        end
      end
      default: begin
      end
    endcase
    v.front = (shadow_len > 0) ? shadow_cells[0] : '0;
    v.back  = (shadow_len > 0) ? shadow_cells[shadow_len-1] : '0;
    v.len   = CNT_W'(shadow_len);
    view_queue.insert(view_queue.size(), v);
  endfunction

  // Queue an operation and track the length it leaves behind
  task automatic push_op(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                         input logic [WIDTH-1:0] val, input bit drain_first = 1'b0);
    list_op_t op;
    op.act = act;
    op.pos = pos;
    op.val = val;
    op.drain_first = drain_first;
    op_queue.insert(op_queue.size(), op);
    case (act)
      ACT_APPEND: if (gen_len < DEPTH) gen_len++;
      ACT_INSERT: if (gen_len < DEPTH && pos <= gen_len) gen_len++;
      ACT_ERASE:  if (gen_len > 0 && pos < gen_len) gen_len--;
      ACT_CLEAR:  gen_len = 0;
      default: begin
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [WIDTH-1:0] want,
                             input logic [WIDTH-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  // Drive words from the pending queue, idling at random
  always @(posedge clk_i or negedge rst_ni) begin
    logic           accept_now;
    logic           nxt_valid;
    logic           go;
    logic [S_W-1:0] word;
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data  <= '0;
      n_sent  <= 0;
    end else begin
      accept_now = s_valid && s_axis_tready_o;
      nxt_valid  = s_valid && !accept_now;
      if (accept_now) begin
        apply_list_op(cur_op);
        n_sent <= n_sent + 1;
      end
      if (!nxt_valid && op_queue.size() != 0) begin
        go = calm || ($urandom_range(99) >= IDLE_PCT);
        // hold off until every outstanding result is back
        if (op_queue[0].drain_first && (accept_now || n_recv != n_sent)) go = 1'b0;
        if (go) begin
          word = '0;
          word[ACT_W-1:0] = op_queue[0].act;
          word[ACT_W+POS_W-1:ACT_W] = op_queue[0].pos;
          word[ACT_W+POS_W+WIDTH-1:ACT_W+POS_W] = op_queue[0].val;
          s_data <= word;
          cur_op <= op_queue[0];
          op_queue.delete(0);
          nxt_valid = 1'b1;
        end
      end
      s_valid <= nxt_valid;
    end
  end

  // Take result words, stall at random, and compare against the oldest view
  always @(posedge clk_i or negedge rst_ni) begin
    list_view_t want;
    if (!rst_ni) begin
      m_ready <= 1'b0;
      n_recv  <= 0;
    end else begin
      if (m_axis_tvalid_o && m_ready) begin
        n_recv <= n_recv + 1;
        if (view_queue.size() == 0) begin
          $error("result word with no expectation pending");
          fail_cnt++;
        end else begin
          want = view_queue.pop_front();
          check_field("read_value", want.rd, m_axis_tdata_o[WIDTH-1:0]);
          check_field("front_value", want.front, m_axis_tdata_o[2*WIDTH-1:WIDTH]);
          check_field("back_value", want.back, m_axis_tdata_o[3*WIDTH-1:2*WIDTH]);
          check_field("element_count", WIDTH'(want.len),
                      WIDTH'(m_axis_tdata_o[3*WIDTH+CNT_W-1:3*WIDTH]));
          check_field("status", WIDTH'(want.st),
                      WIDTH'(m_axis_tdata_o[3*WIDTH+CNT_W+ST_W-1:3*WIDTH+CNT_W]));
        end
      end
      m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    #400_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int a;
    int k;
    int r;
    int mode;
    int add_w;
    logic [ACT_W-1:0] act;
    logic [POS_W-1:0] pos;
    logic [WIDTH-1:0] val;

    // Corner cases on an empty and a short list
    push_op(ACT_READ, '0, WIDTH'($urandom));
    push_op(ACT_ERASE, '0, WIDTH'($urandom));
    push_op(ACT_APPEND, '0, '1);
    push_op(ACT_INSERT, '0, '0);
    push_op(ACT_INSERT, 5'd2, 32'hA5A5_5A5A);
    push_op(ACT_INSERT, '1, WIDTH'($urandom));
    push_op(ACT_READ, 5'd1, '1);
    push_op(ACT_READ, 5'd3, WIDTH'($urandom));
    push_op(ACT_ERASE, '1, WIDTH'($urandom));
    push_op(ACT_ERASE, 5'd1, WIDTH'($urandom));
    for (a = int'(ACT_READ) + 1; a < (1 << ACT_W); a++) push_op(ACT_W'(a), '1, '1);

    // Fill to capacity, then hit the full cases
    while (gen_len < DEPTH) push_op(ACT_APPEND, POS_W'($urandom), WIDTH'($urandom));
    push_op(ACT_APPEND, '0, WIDTH'($urandom));
    push_op(ACT_INSERT, '1, WIDTH'($urandom));
    push_op(ACT_READ, POS_W'(DEPTH - 1), WIDTH'($urandom));
    push_op(ACT_ERASE, '0, WIDTH'($urandom));
    push_op(ACT_CLEAR, POS_W'($urandom), WIDTH'($urandom));

    // Random traffic drifting between filling, draining and balanced phases
    mode = 0;
    for (k = 0; k < RANDOM_OPS; k++) begin
      if (k % 50 == 0) mode = $urandom_range(2);
      add_w = (mode == 0) ? 70 : (mode == 1) ? 20 : 45;
      r = $urandom_range(99);
      if (r < 2) act = ACT_CLEAR;
      else if (r < 5) act = ACT_W'($urandom_range((1 << ACT_W) - 1, int'(ACT_READ) + 1));
      else if (r < 5 + add_w / 2) act = ACT_APPEND;
      else if (r < 5 + add_w) act = ACT_INSERT;
      else if (r < 5 + add_w + (95 - add_w) / 2) act = ACT_ERASE;
      else act = ACT_READ;

      if ($urandom_range(99) < 15) pos = POS_W'($urandom);
      else if (act == ACT_INSERT) pos = POS_W'($urandom_range(gen_len));
      else pos = (gen_len > 0) ? POS_W'($urandom_range(gen_len - 1)) : '0;

      r = $urandom_range(9);
      val = (r == 0) ? '0 : (r == 1) ? '1 : WIDTH'($urandom);
      push_op(act, pos, val, (k == 0) || (k == 700));
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sample the end condition away from the active edge
    while (op_queue.size() != 0 || s_valid || n_recv != n_sent) @(negedge clk_i);
    repeat (10) @(posedge clk_i);

    if (view_queue.size() != 0) begin
      $error("%0d expected results never arrived", view_queue.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ indexed_shift_list_unit.f @@
rtl/isl_pkg.sv
rtl/isl_cell.sv
rtl/indexed_shift_list_unit.sv
tb/tb_indexed_shift_list_unit.sv
